[sv/mrs_pkg.sv]
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared types, constants and the CRC-16 step for the register server.
// ----------------------------------------------------------------------------
package mrs_pkg;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [7:0]  ADDR_RESET = 8'd1;
    localparam logic [7:0]  FN_READ_HOLD   = 8'd3;
    localparam logic [7:0]  FN_READ_INPUT  = 8'd4;
    localparam logic [7:0]  FN_WRITE_MULTI = 8'd16;
    localparam int          HDR_BYTES     = 7;
    localparam int          READ_FRAME_LEN = 8;
    localparam int          WR_DATA_POS    = 7;
    localparam int          WR_FRAME_BASE  = 9;

    typedef struct packed {
        logic        kind;
        logic [7:0]  frame_byte;
        logic        frame_end;
        logic [5:0]  reg_index;
        logic [15:0] reg_value;
    } item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_last;
    } result_t;

    typedef enum logic {
        OP_BYTE,
        OP_SET
    } op_t;

    typedef struct packed {
        logic  valid;
        op_t   op;
        item_t item;
    } qif_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_JUDGE,
        ST_WR_A,
        ST_WR_B,
        ST_WR_C,
        ST_TX_ADDR,
        ST_TX_FN,
        ST_TX_CNT,
        ST_TX_RD,
        ST_TX_HI,
        ST_TX_LO,
        ST_TX_CRCL,
        ST_TX_CRCH
    } st_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

[sv/modbus_rtu_slave_register_server.sv]
// The back end takes each queued byte while idle; a frame end leads to a judge
// state, then a write passes through WR_A, WR_B and WR_C per register and a read
// reply sends 3 header bytes, 2 bytes per register word and 2 CRC bytes.
// Throughput: one item per cycle while the back end is idle; the 2-deep queue
// raises busy once both entries fill while a frame is judged, written or answered.
// Reset clears registers to zero, address to 1; results cannot be stalled.
// ----------------------------------------------------------------------------
// modbus_rtu_slave_register_server
// Top level: command front end, queue, and register server back end.
// ----------------------------------------------------------------------------
module modbus_rtu_slave_register_server #(
    parameter int REG_COUNT     = 64,
    parameter int FRAME_BYTES   = 256,
    parameter int MAX_READ_REGS = 29
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  mrs_pkg::item_t    item,
    output logic              busy,
    input  logic              wr_en,
    input  logic [7:0]        wr_data,
    output mrs_pkg::result_t  result,
    output logic              result_valid
);

    mrs_pkg::qif_t q_head;
    logic          q_pop;

    mrs_front #(.REG_COUNT(REG_COUNT)) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .q_head (q_head),
        .q_pop  (q_pop)
    );

    mrs_back #(
        .REG_COUNT     (REG_COUNT),
        .FRAME_BYTES   (FRAME_BYTES),
        .MAX_READ_REGS (MAX_READ_REGS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .wr_en        (wr_en),
        .wr_data      (wr_data),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

[sv/mrs_front.sv]
// ----------------------------------------------------------------------------
// mrs_front
// Accepts items, classifies them and queues them (two deep) for the back end.
// ----------------------------------------------------------------------------
module mrs_front #(
    parameter int REG_COUNT = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  mrs_pkg::item_t   item,
    output logic             busy,
    output mrs_pkg::qif_t    q_head,
    input  logic             q_pop
);

    mrs_pkg::op_t   op_mem [2];
    mrs_pkg::item_t it_mem [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] fill_reg, fill_next;
    logic       accept, keep, pop;

    assign busy   = (fill_reg == 2'd2);
    assign accept = start && !busy;
    // out-of-range register sets are dropped here
    assign keep   = accept && !(item.kind && (32'(item.reg_index) >= REG_COUNT));
    assign pop    = q_pop && (fill_reg != 2'd0);

    always_comb
    begin
        wp_next   = wp_reg ^ keep;
        rp_next   = rp_reg ^ pop;
        fill_next = fill_reg + {1'b0, keep} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            op_mem[wp_reg] <= item.kind ? mrs_pkg::OP_SET : mrs_pkg::OP_BYTE;
            it_mem[wp_reg] <= item;
        end
    end

    assign q_head.valid = (fill_reg != 2'd0);
    assign q_head.op    = op_mem[rp_reg];
    assign q_head.item  = it_mem[rp_reg];

endmodule

[sv/mrs_back.sv]
// ----------------------------------------------------------------------------
// mrs_back
// Frame assembly, CRC check, request judging, register writes and replies.
// ----------------------------------------------------------------------------
module mrs_back #(
    parameter int REG_COUNT     = 64,
    parameter int FRAME_BYTES   = 256,
    parameter int MAX_READ_REGS = 29
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mrs_pkg::qif_t     q_head,
    output logic              q_pop,
    input  logic              wr_en,
    input  logic [7:0]        wr_data,
    output mrs_pkg::result_t  result,
    output logic              result_valid
);

    localparam int RIDX_W = $clog2(REG_COUNT);
    localparam int REM_W  = $clog2(REG_COUNT + 1);
    localparam int FB_W   = $clog2(FRAME_BYTES);
    localparam int CNT_W  = $clog2(FRAME_BYTES + 2);

    mrs_pkg::st_t st_reg, st_next;

    logic [7:0]  fs_mem [FRAME_BYTES];
    logic [15:0] h_mem  [REG_COUNT];
    logic [15:0] i_mem  [REG_COUNT];
    logic [REG_COUNT-1:0] hvalid_reg, ivalid_reg;

    logic [7:0]  hdr_reg [mrs_pkg::HDR_BYTES];
    logic [7:0]  addr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] txcrc_reg, txcrc_next;
    logic [RIDX_W-1:0] ra_reg, ra_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [FB_W-1:0]   ptr_reg, ptr_next;
    logic [7:0]  hi_reg, hi_next;
    logic [7:0]  lo_reg, lo_next;
    logic        bank_reg, bank_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;
    logic        out_valid_reg, out_valid_next;

    logic [7:0]  fs_rd_reg;
    logic [15:0] h_rd_reg, i_rd_reg;
    logic        hv_rd_reg, iv_rd_reg;

    logic        pop_byte, pop_set, fs_we, h_we;
    logic [15:0] fn_start, fn_qty, rd_word;
    logic        span_ok, frame_ok, wr_ok, rd_ok;
    logic [7:0]  emit_byte;
    logic        emit;

    assign q_pop    = (st_reg == mrs_pkg::ST_IDLE) && q_head.valid;
    assign pop_byte = q_pop && (q_head.op == mrs_pkg::OP_BYTE);
    assign pop_set  = q_pop && (q_head.op == mrs_pkg::OP_SET);
    assign fs_we    = pop_byte && (cnt_reg < CNT_W'(FRAME_BYTES));
    assign h_we     = (st_reg == mrs_pkg::ST_WR_C);

    assign fn_start = {hdr_reg[2], hdr_reg[3]};
    assign fn_qty   = {hdr_reg[4], hdr_reg[5]};
    assign span_ok  = (fn_qty != 16'd0) && (32'(fn_start) < REG_COUNT)
                   && ((17'(fn_start) + 17'(fn_qty)) <= 17'(REG_COUNT));
    assign frame_ok = (cnt_reg <= CNT_W'(FRAME_BYTES))
                   && (cnt_reg >= CNT_W'(mrs_pkg::READ_FRAME_LEN))
                   && (crc_reg == 16'h0000) && (hdr_reg[0] == addr_reg) && span_ok;
    assign wr_ok    = (hdr_reg[1] == mrs_pkg::FN_WRITE_MULTI)
                   && (17'(hdr_reg[6]) == {1'b0, fn_qty[14:0], 1'b0}) && !fn_qty[15]
                   && (10'(cnt_reg) == (10'(mrs_pkg::WR_FRAME_BASE) + 10'(hdr_reg[6])));
    assign rd_ok    = ((hdr_reg[1] == mrs_pkg::FN_READ_HOLD)
                    || (hdr_reg[1] == mrs_pkg::FN_READ_INPUT))
                   && (cnt_reg == CNT_W'(mrs_pkg::READ_FRAME_LEN))
                   && (32'(fn_qty) <= MAX_READ_REGS);
    assign rd_word  = bank_reg ? (iv_rd_reg ? i_rd_reg : 16'h0000)
                               : (hv_rd_reg ? h_rd_reg : 16'h0000);

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            mrs_pkg::ST_IDLE:
                if (pop_byte && q_head.item.frame_end)
                    st_next = mrs_pkg::ST_JUDGE;
            mrs_pkg::ST_JUDGE:
                if (frame_ok && wr_ok)
                    st_next = mrs_pkg::ST_WR_A;
                else if (frame_ok && rd_ok)
                    st_next = mrs_pkg::ST_TX_ADDR;
                else
                    st_next = mrs_pkg::ST_IDLE;
            mrs_pkg::ST_WR_A:    st_next = mrs_pkg::ST_WR_B;
            mrs_pkg::ST_WR_B:    st_next = mrs_pkg::ST_WR_C;
            mrs_pkg::ST_WR_C:
                st_next = (rem_reg == REM_W'(1)) ? mrs_pkg::ST_IDLE : mrs_pkg::ST_WR_A;
            mrs_pkg::ST_TX_ADDR: st_next = mrs_pkg::ST_TX_FN;
            mrs_pkg::ST_TX_FN:   st_next = mrs_pkg::ST_TX_CNT;
            mrs_pkg::ST_TX_CNT:  st_next = mrs_pkg::ST_TX_RD;
            mrs_pkg::ST_TX_RD:   st_next = mrs_pkg::ST_TX_HI;
            mrs_pkg::ST_TX_HI:   st_next = mrs_pkg::ST_TX_LO;
            mrs_pkg::ST_TX_LO:
                st_next = (rem_reg == REM_W'(1)) ? mrs_pkg::ST_TX_CRCL : mrs_pkg::ST_TX_RD;
            mrs_pkg::ST_TX_CRCL: st_next = mrs_pkg::ST_TX_CRCH;
            mrs_pkg::ST_TX_CRCH: st_next = mrs_pkg::ST_IDLE;
            default:             st_next = mrs_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cnt_next      = cnt_reg;
        crc_next      = crc_reg;
        txcrc_next    = txcrc_reg;
        ra_next       = ra_reg;
        rem_next      = rem_reg;
        ptr_next      = ptr_reg;
        hi_next       = hi_reg;
        lo_next       = lo_reg;
        bank_next     = bank_reg;
        out_byte_next = out_byte_reg;
        out_last_next = 1'b0;
        emit          = 1'b0;
        emit_byte     = 8'h00;
        case (st_reg)
            mrs_pkg::ST_IDLE:
                if (pop_byte)
                begin
                    if (cnt_reg <= CNT_W'(FRAME_BYTES))
                        cnt_next = cnt_reg + CNT_W'(1);
                    crc_next = mrs_pkg::crc_feed(crc_reg, q_head.item.frame_byte);
                end
            mrs_pkg::ST_JUDGE:
            begin
                cnt_next   = '0;
                crc_next   = mrs_pkg::CRC_INIT;
                txcrc_next = mrs_pkg::CRC_INIT;
                ra_next    = RIDX_W'(fn_start);
                rem_next   = REM_W'(fn_qty);
                ptr_next   = FB_W'(mrs_pkg::WR_DATA_POS);
                bank_next  = (hdr_reg[1] == mrs_pkg::FN_READ_INPUT);
            end
            mrs_pkg::ST_WR_A:
                ptr_next = ptr_reg + FB_W'(1);
            mrs_pkg::ST_WR_B:
            begin
                hi_next  = fs_rd_reg;
                ptr_next = ptr_reg + FB_W'(1);
            end
            mrs_pkg::ST_WR_C:
            begin
                ra_next  = ra_reg + RIDX_W'(1);
                rem_next = rem_reg - REM_W'(1);
            end
            mrs_pkg::ST_TX_ADDR:
            begin
                emit      = 1'b1;
                emit_byte = addr_reg;
            end
            mrs_pkg::ST_TX_FN:
            begin
                emit      = 1'b1;
                emit_byte = hdr_reg[1];
            end
            mrs_pkg::ST_TX_CNT:
            begin
                emit      = 1'b1;
                emit_byte = {fn_qty[6:0], 1'b0};
            end
            mrs_pkg::ST_TX_RD: ;
            mrs_pkg::ST_TX_HI:
            begin
                emit      = 1'b1;
                emit_byte = rd_word[15:8];
                lo_next   = rd_word[7:0];
            end
            mrs_pkg::ST_TX_LO:
            begin
                emit      = 1'b1;
                emit_byte = lo_reg;
                ra_next   = ra_reg + RIDX_W'(1);
                rem_next  = rem_reg - REM_W'(1);
            end
            mrs_pkg::ST_TX_CRCL:
            begin
                emit      = 1'b1;
                emit_byte = txcrc_reg[7:0];
            end
            mrs_pkg::ST_TX_CRCH:
            begin
                emit          = 1'b1;
                emit_byte     = txcrc_reg[15:8];
                out_last_next = 1'b1;
            end
            default: ;
        endcase
        out_valid_next = emit;
        if (emit)
            out_byte_next = emit_byte;
        if (emit && (st_reg != mrs_pkg::ST_TX_CRCL) && (st_reg != mrs_pkg::ST_TX_CRCH))
            txcrc_next = mrs_pkg::crc_feed(txcrc_reg, emit_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= mrs_pkg::ST_IDLE;
            addr_reg      <= mrs_pkg::ADDR_RESET;
            cnt_reg       <= '0;
            crc_reg       <= mrs_pkg::CRC_INIT;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            hvalid_reg    <= '0;
            ivalid_reg    <= '0;
        end
        else
        begin
            st_reg        <= st_next;
            cnt_reg       <= cnt_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
            if (wr_en)
                addr_reg <= wr_data;
            if (h_we)
                hvalid_reg[ra_reg] <= 1'b1;
            if (pop_set)
                ivalid_reg[RIDX_W'(q_head.item.reg_index)] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        txcrc_reg    <= txcrc_next;
        ra_reg       <= ra_next;
        rem_reg      <= rem_next;
        ptr_reg      <= ptr_next;
        hi_reg       <= hi_next;
        lo_reg       <= lo_next;
        bank_reg     <= bank_next;
        out_byte_reg <= out_byte_next;
        if (pop_byte && (cnt_reg < CNT_W'(mrs_pkg::HDR_BYTES)))
            hdr_reg[cnt_reg[2:0]] <= q_head.item.frame_byte;
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (fs_we)
            fs_mem[cnt_reg[FB_W-1:0]] <= q_head.item.frame_byte;
        fs_rd_reg <= fs_mem[ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (h_we)
            h_mem[ra_reg] <= {hi_reg, fs_rd_reg};
        h_rd_reg  <= h_mem[ra_reg];
        hv_rd_reg <= hvalid_reg[ra_reg];
    end

    always_ff @(posedge clk)
    begin
        if (pop_set)
            i_mem[RIDX_W'(q_head.item.reg_index)] <= q_head.item.reg_value;
        i_rd_reg  <= i_mem[ra_reg];
        iv_rd_reg <= ivalid_reg[ra_reg];
    end

    assign result.tx_byte = out_byte_reg;
    assign result.tx_last = out_last_reg;
    assign result_valid   = out_valid_reg;

endmodule

[sv/mrs_checker.sv]
// ----------------------------------------------------------------------------
// mrs_checker
// Port-level checks on reply framing and queue back-pressure.
// ----------------------------------------------------------------------------
module mrs_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input mrs_pkg::result_t  result,
    input logic              result_valid
);

    // a reply ends with a gap
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.tx_last |=> !result_valid)
        else $error("word after final reply byte");

    // address and function go out back to back
    a_head_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |=> result_valid)
        else $error("reply header broken");

    a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !result.tx_last)
        else $error("reply too short");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without a new item");

endmodule

bind modbus_rtu_slave_register_server mrs_checker u_mrs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result       (result),
    .result_valid (result_valid)
);

[dv/modbus_rtu_slave_register_server_tb.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_slave_register_server_tb
// Drives request frames and input register updates into the register server,
// predicts every reply byte and checks each strobed word in order.
// ----------------------------------------------------------------------------
module modbus_rtu_slave_register_server_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NREG   = 64;
    localparam int NFRAME = 256;
    localparam int NREAD  = 29;

    logic              clk;
    logic              rst_n;
    logic              start;
    mrs_pkg::item_t    item;
    logic              busy;
    logic              wr_en;
    logic [7:0]        wr_data;
    mrs_pkg::result_t  result;
    logic              result_valid;

    // predictor state
    logic [7:0]  pr_addr;
    logic [15:0] pr_hold [NREG];
    logic [15:0] pr_inp  [NREG];
    logic [7:0]  pr_frame [NFRAME];
    int          pr_count;
    logic [15:0] pr_crc;

    mrs_pkg::result_t reply_q [$];
    int          fail_cnt;
    int          sent_cnt;

    typedef struct {
        mrs_pkg::item_t it;
        int             nexp;     // -1: check with predictor only
    } row_t;

    modbus_rtu_slave_register_server u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .wr_en        (wr_en),
        .wr_data      (wr_data),
        .result       (result),
        .result_valid (result_valid)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        end
        return r;
    endfunction

    function automatic logic [15:0] fword(input int p);
        return {pr_frame[p], pr_frame[p + 1]};
    endfunction

    // frame judged at its last byte; read replies are queued
    task automatic judge_request();
        int               len;
        int               fn;
        int               st;
        int               qty;
        logic [15:0]      c;
        logic [7:0]       rb [$];
        logic [15:0]      w;
        mrs_pkg::result_t r;
        len = pr_count;
        if (len > NFRAME || len < 8 || pr_crc != 16'h0000) return;
        if (pr_frame[0] != pr_addr) return;
        fn  = pr_frame[1];
        st  = fword(2);
        qty = fword(4);
        if (qty == 0 || st >= NREG || qty > NREG - st) return;
        if (fn == mrs_pkg::FN_WRITE_MULTI)
        begin
            if (pr_frame[6] != 2 * qty || len != 9 + pr_frame[6]) return;
            for (int i = 0; i < qty; i++)
                pr_hold[st + i] = fword(mrs_pkg::WR_DATA_POS + 2 * i);
            return;
        end
        if (fn != mrs_pkg::FN_READ_HOLD && fn != mrs_pkg::FN_READ_INPUT) return;
        if (len != mrs_pkg::READ_FRAME_LEN || qty > NREAD) return;
        rb.push_back(pr_addr);
        rb.push_back(fn[7:0]);
        rb.push_back(8'(2 * qty));
        for (int i = 0; i < qty; i++)
        begin
            w = (fn == mrs_pkg::FN_READ_HOLD) ? pr_hold[st + i] : pr_inp[st + i];
            rb.push_back(w[15:8]);
            rb.push_back(w[7:0]);
        end
        c = 16'hFFFF;
        foreach (rb[i]) c = crc_step(c, rb[i]);
        rb.push_back(c[7:0]);
        rb.push_back(c[15:8]);
        foreach (rb[i])
        begin
            r.tx_byte = rb[i];
            r.tx_last = (i == rb.size() - 1);
            reply_q.push_back(r);
        end
    endtask

    task automatic predict_item(input mrs_pkg::item_t it);
        if (it.kind)
        begin
            pr_inp[it.reg_index] = it.reg_value;
            return;
        end
        if (pr_count < NFRAME) pr_frame[pr_count] = it.frame_byte;
        if (pr_count <= NFRAME) pr_count++;
        pr_crc = crc_step(pr_crc, it.frame_byte);
        if (it.frame_end)
        begin
            judge_request();
            pr_count = 0;
            pr_crc   = 16'hFFFF;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        mrs_pkg::result_t e;
        if (rst_n && result_valid)
        begin
            if (reply_q.size() == 0)
            begin
                $error("unexpected word tx_byte=%h tx_last=%b", result.tx_byte, result.tx_last);
                fail_cnt++;
            end
            else
            begin
                e = reply_q.pop_front();
                if (result.tx_byte !== e.tx_byte)
                begin
                    $error("tx_byte expected %h actual %h", e.tx_byte, result.tx_byte);
                    fail_cnt++;
                end
                if (result.tx_last !== e.tx_last)
                begin
                    $error("tx_last expected %b actual %b", e.tx_last, result.tx_last);
                    fail_cnt++;
                end
            end
        end
    end

    // start stays high between back-to-back words; callers that wait drop it
    task automatic send_item(input mrs_pkg::item_t it);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_item(it);
        sent_cnt++;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (reply_q.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (300) @(posedge clk);
    endtask

    task automatic set_address(input logic [7:0] a);
        drain();
        wr_en   <= 1'b1;
        wr_data <= a;
        @(posedge clk);
        wr_en   <= 1'b0;
        pr_addr = a;
    endtask

    function automatic mrs_pkg::item_t byte_item(input logic [7:0] b, input logic last);
        mrs_pkg::item_t it;
        it = '0;
        it.kind       = mrs_pkg::OP_BYTE;
        it.frame_byte = b;
        it.frame_end  = last;
        it.reg_index  = 6'($urandom);
        it.reg_value  = 16'($urandom);
        return it;
    endfunction

    function automatic mrs_pkg::item_t set_item(input logic [5:0] idx, input logic [15:0] v);
        mrs_pkg::item_t it;
        it = '0;
        it.kind       = mrs_pkg::OP_SET;
        it.frame_byte = 8'($urandom);
        it.frame_end  = 1'($urandom);
        it.reg_index  = idx;
        it.reg_value  = v;
        return it;
    endfunction

    // send a frame with its CRC appended; corrupt flips one CRC bit
    task automatic send_frame(input logic [7:0] body [$], input bit corrupt, input bit noise);
        logic [15:0] c;
        c = 16'hFFFF;
        foreach (body[i]) c = crc_step(c, body[i]);
        if (corrupt) c[$urandom_range(0, 15)] ^= 1'b1;
        body.push_back(c[7:0]);
        body.push_back(c[15:8]);
        foreach (body[i])
        begin
            if (noise && $urandom_range(0, 5) == 0)
                send_item(set_item(6'($urandom), 16'($urandom)));
            send_item(byte_item(body[i], i == body.size() - 1));
        end
    endtask

    task automatic read_frame(input logic [7:0] a, input logic [7:0] fn,
                              input int st, input int qty, input bit corrupt);
        logic [7:0] b [$];
        b = '{a, fn, 8'(st >> 8), 8'(st), 8'(qty >> 8), 8'(qty)};
        send_frame(b, corrupt, 1'b1);
    endtask

    task automatic write_frame(input logic [7:0] a, input int st, input int qty,
                               input int cnt, input int ndata);
        logic [7:0] b [$];
        b = '{a, mrs_pkg::FN_WRITE_MULTI, 8'(st >> 8), 8'(st), 8'(qty >> 8), 8'(qty),
              8'(cnt)};
        repeat (ndata) b.push_back(8'($urandom));
        send_frame(b, 1'b0, 1'b1);
    endtask

    initial
    begin
        row_t        rows [$];
        row_t        rw;
        logic [7:0]  b [$];
        logic [7:0]  a;
        int          q;
        int          s;
        int          sel;
        fail_cnt = 0;
        sent_cnt = 0;
        rst_n   = 1'b0;
        start   = 1'b0;
        item    = '0;
        wr_en   = 1'b0;
        wr_data = '0;
        pr_addr = mrs_pkg::ADDR_RESET;
        pr_count = 0;
        pr_crc   = 16'hFFFF;
        for (int i = 0; i < NREG; i++) begin pr_hold[i] = '0; pr_inp[i] = '0; end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: set items at extremes, two lone end bytes
        rw.nexp = 0;
        rw.it = set_item(6'd0, 16'hFFFF);         rows.push_back(rw);
        rw.it = set_item(6'd63, 16'h0000);        rows.push_back(rw);
        rw.it = set_item(6'd63, 16'hA5C3);        rows.push_back(rw);
        rw.it = set_item(6'd1, 16'h5A3C);         rows.push_back(rw);
        rw.it = byte_item(8'hFF, 1'b1);           rows.push_back(rw);
        rw.it = byte_item(8'h00, 1'b1);           rows.push_back(rw);
        foreach (rows[i])
        begin
            send_item(rows[i].it);
            if (rows[i].nexp == 0 && reply_q.size() != 0)
            begin
                $error("row %0d expected no word", i);
                fail_cnt++;
            end
        end

        // read after reset: holding all zero, then inputs
        read_frame(8'd1, mrs_pkg::FN_READ_HOLD, 0, 1, 1'b0);
        read_frame(8'd1, mrs_pkg::FN_READ_INPUT, 63, 1, 1'b0);
        read_frame(8'd1, mrs_pkg::FN_READ_HOLD, 0, NREAD, 1'b0);
        read_frame(8'd1, mrs_pkg::FN_READ_HOLD, 0, NREAD + 1, 1'b0);  // too many
        read_frame(8'd1, mrs_pkg::FN_READ_HOLD, 0, 0, 1'b0);          // quantity zero
        read_frame(8'd1, mrs_pkg::FN_READ_HOLD, 60, 5, 1'b0);         // past end
        read_frame(8'd1, mrs_pkg::FN_READ_HOLD, 0, 1, 1'b1);          // bad CRC
        read_frame(8'd2, mrs_pkg::FN_READ_HOLD, 0, 1, 1'b0);          // foreign address
        read_frame(8'd1, 8'd5, 0, 1, 1'b0);                           // unknown function
        write_frame(8'd1, 0, 4, 8, 8);
        write_frame(8'd1, 10, 2, 3, 3);                               // bad byte count
        read_frame(8'd1, mrs_pkg::FN_READ_HOLD, 0, 4, 1'b0);
        // short read frame (7 bytes with valid CRC)
        b = '{8'd1, mrs_pkg::FN_READ_HOLD, 8'd0, 8'd0, 8'd1};
        send_frame(b, 1'b0, 1'b0);
        drain();  // sender pauses until all replies arrive

        set_address(8'd247);
        read_frame(8'd247, mrs_pkg::FN_READ_INPUT, 0, 3, 1'b0);

        // random part across two addresses
        for (int ph = 0; ph < 2; ph++)
        begin
            a = (ph == 0) ? 8'd1 : 8'($urandom_range(1, 247));
            set_address(a);
            for (int n = 0; n < 2; n++)
            begin
                sel = $urandom_range(0, 9);
                q = $urandom_range(0, 3) == 0 ? $urandom_range(1, NREAD) : $urandom_range(1, 6);
                s = $urandom_range(0, NREG - q);
                if (sel < 4)
                    read_frame(($urandom_range(0, 9) == 0) ? 8'($urandom) : a,
                               $urandom_range(0, 1) ? mrs_pkg::FN_READ_HOLD
                                                    : mrs_pkg::FN_READ_INPUT,
                               s, q, $urandom_range(0, 9) == 0);
                else if (sel < 6)
                    write_frame(a, s, q, 2 * q, 2 * q);
                else if (sel < 8)
                    send_item(set_item(6'($urandom), 16'($urandom)));
                else
                    send_item(byte_item(8'($urandom), $urandom_range(0, 3) == 0));
            end
            // close any partial frame
            send_item(byte_item(8'($urandom), 1'b1));
        end

        drain();
        if (reply_q.size() != 0)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        if (fail_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[files.f]
sv/mrs_pkg.sv
sv/mrs_front.sv
sv/mrs_back.sv
sv/modbus_rtu_slave_register_server.sv
sv/mrs_checker.sv
dv/modbus_rtu_slave_register_server_tb.sv
